>>> hdl/msa_pkg.sv
package msa_pkg;

    localparam int NUM_MOMENTS = 21;

    // commands carried in s_axis_tuser
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_X_LO = 3'd0;
    localparam logic [2:0] CFG_X_HI = 3'd1;
    localparam logic [2:0] CFG_Y_LO = 3'd2;
    localparam logic [2:0] CFG_Y_HI = 3'd3;
    localparam logic [2:0] CFG_MODE = 3'd4;

    // readout indexes past the moments
    localparam logic [4:0] IDX_COUNT = 5'd21;
    localparam logic [4:0] IDX_MIN   = 5'd22;
    localparam logic [4:0] IDX_MAX   = 5'd23;

    // sequencer steps
    localparam logic [4:0] STEP_H0   = 5'd0;
    localparam logic [4:0] STEP_LAST = 5'd20;

    // largest Q1.30 offset magnitude
    localparam logic [65:0] OFFS_LIM = 66'h7FFF_FFFF;

    // operand A selects
    localparam logic [3:0] A_ZH  = 4'd0;
    localparam logic [3:0] A_D0  = 4'd1;
    localparam logic [3:0] A_D1  = 4'd2;
    localparam logic [3:0] A_P0  = 4'd3;
    localparam logic [3:0] A_P1  = 4'd4;
    localparam logic [3:0] A_XX  = 4'd5;
    localparam logic [3:0] A_XY  = 4'd6;
    localparam logic [3:0] A_YY  = 4'd7;
    localparam logic [3:0] A_XXX = 4'd8;
    localparam logic [3:0] A_XXY = 4'd9;
    localparam logic [3:0] A_YYY = 4'd10;

    // operand B selects
    localparam logic [2:0] B_ONE = 3'd0;
    localparam logic [2:0] B_INV = 3'd1;
    localparam logic [2:0] B_ZH  = 3'd2;
    localparam logic [2:0] B_P0  = 3'd3;
    localparam logic [2:0] B_P1  = 3'd4;

    // product scaling
    localparam logic [1:0] SH_0   = 2'd0;
    localparam logic [1:0] SH_16  = 2'd1;
    localparam logic [1:0] SH_30  = 2'd2;
    localparam logic [1:0] SH_VAR = 2'd3;

    // temporary destinations
    localparam logic [3:0] T_NONE = 4'd0;
    localparam logic [3:0] T_P0   = 4'd1;
    localparam logic [3:0] T_P1   = 4'd2;
    localparam logic [3:0] T_XX   = 4'd3;
    localparam logic [3:0] T_XY   = 4'd4;
    localparam logic [3:0] T_YY   = 4'd5;
    localparam logic [3:0] T_XXX  = 4'd6;
    localparam logic [3:0] T_XXY  = 4'd7;
    localparam logic [3:0] T_YYY  = 4'd8;

    typedef struct packed {
        logic [3:0] opa;
        logic [2:0] opb;
        logic [1:0] shk;
        logic [4:0] acc;
        logic [3:0] tdst;
    } step_t;

    typedef struct packed {
        logic [31:0] x_lo;
        logic [31:0] x_hi;
        logic [31:0] y_lo;
        logic [31:0] y_hi;
        logic        terrain;
        logic [31:0] inv;
        logic [5:0]  inv_shift;
        logic        busy;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       issue;
        logic [4:0] step;
        logic       rd_load;
        logic [4:0] rd_idx;
    } cmd_t;

    // multiply schedule; each operand is written back before the step that reads it
    function automatic step_t step_info(input logic [4:0] step);
        step_t s;
        case (step)
            5'd0:    s = '{A_ZH,  B_ONE, SH_0,   5'd14, T_NONE};
            5'd1:    s = '{A_D0,  B_INV, SH_VAR, 5'd0,  T_P0};
            5'd2:    s = '{A_D1,  B_INV, SH_VAR, 5'd1,  T_P1};
            5'd3:    s = '{A_P0,  B_ZH,  SH_30,  5'd15, T_NONE};
            5'd4:    s = '{A_P0,  B_P0,  SH_30,  5'd3,  T_XX};
            5'd5:    s = '{A_P0,  B_P1,  SH_30,  5'd2,  T_XY};
            5'd6:    s = '{A_P1,  B_P1,  SH_30,  5'd5,  T_YY};
            5'd7:    s = '{A_P1,  B_ZH,  SH_30,  5'd16, T_NONE};
            5'd8:    s = '{A_ZH,  B_ZH,  SH_16,  5'd18, T_NONE};
            5'd9:    s = '{A_XX,  B_P0,  SH_30,  5'd8,  T_XXX};
            5'd10:   s = '{A_XX,  B_P1,  SH_30,  5'd4,  T_XXY};
            5'd11:   s = '{A_XX,  B_ZH,  SH_30,  5'd19, T_NONE};
            5'd12:   s = '{A_XY,  B_P1,  SH_30,  5'd6,  T_NONE};
            5'd13:   s = '{A_XY,  B_ZH,  SH_30,  5'd17, T_NONE};
            5'd14:   s = '{A_YY,  B_P1,  SH_30,  5'd9,  T_YYY};
            5'd15:   s = '{A_YY,  B_ZH,  SH_30,  5'd20, T_NONE};
            5'd16:   s = '{A_XXX, B_P0,  SH_30,  5'd10, T_NONE};
            5'd17:   s = '{A_XXX, B_P1,  SH_30,  5'd12, T_NONE};
            5'd18:   s = '{A_XXY, B_P1,  SH_30,  5'd7,  T_NONE};
            5'd19:   s = '{A_YYY, B_P1,  SH_30,  5'd11, T_NONE};
            5'd20:   s = '{A_YYY, B_P0,  SH_30,  5'd13, T_NONE};
            default: s = '{A_ZH,  B_ONE, SH_0,   5'd14, T_NONE};
        endcase
        return s;
    endfunction

endpackage

>>> hdl/msa_recip.sv
// Config registers and the extent reciprocal: normalize one bit a cycle,
// then restoring divide of 2^63-1, one quotient bit a cycle.
module msa_recip
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    output msa_pkg::cfg_t       cfg
);

    localparam logic [1:0] RS_IDLE = 2'd0;
    localparam logic [1:0] RS_LOAD = 2'd1;
    localparam logic [1:0] RS_NORM = 2'd2;
    localparam logic [1:0] RS_DIV  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [31:0] x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg;
    logic        mode_reg;
    logic [31:0] inv_reg, inv_next;
    logic [5:0]  shift_reg, shift_next;
    logic [31:0] hn_reg, hn_next;
    logic [4:0]  z_reg, z_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic signed [32:0] dx, dy, h;
    logic [32:0]        trial;
    logic               bound_we;

    assign bound_we = cfg_we && (cfg_index <= msa_pkg::CFG_Y_HI);

    always_comb
    begin
        dx    = $signed({x_hi_reg[31], x_hi_reg}) - $signed({x_lo_reg[31], x_lo_reg});
        dy    = $signed({y_hi_reg[31], y_hi_reg}) - $signed({y_lo_reg[31], y_lo_reg});
        h     = (dx > dy) ? dx : dy;
        trial = {rem_reg, 1'b1};

        state_next = state_reg;
        inv_next   = inv_reg;
        shift_next = shift_reg;
        hn_next    = hn_reg;
        z_next     = z_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;

        case (state_reg)
            RS_IDLE:
            begin
            end
            RS_LOAD:
            begin
                if (h[32] || (h == 33'sd0))
                begin
                    inv_next   = '0;
                    shift_next = '0;
                    state_next = RS_IDLE;
                end
                else
                begin
                    hn_next    = h[31:0];
                    z_next     = '0;
                    state_next = RS_NORM;
                end
            end
            RS_NORM:
            begin
                if (hn_reg[31])
                begin
                    rem_next   = 32'h7FFF_FFFF;
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = RS_DIV;
                end
                else
                begin
                    hn_next = {hn_reg[30:0], 1'b0};
                    z_next  = z_reg + 5'd1;
                end
            end
            RS_DIV:
            begin
                if (trial >= {1'b0, hn_reg})
                begin
                    rem_next = 32'(trial - {1'b0, hn_reg});
                    q_next   = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[31:0];
                    q_next   = {q_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    inv_next   = q_next;
                    shift_next = 6'd34 - {1'b0, z_reg};
                    state_next = RS_IDLE;
                end
            end
            default:
            begin
                state_next = RS_IDLE;
            end
        endcase

        if (bound_we)
        begin
            state_next = RS_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RS_IDLE;
            x_lo_reg  <= 32'd0;
            x_hi_reg  <= 32'd65536;
            y_lo_reg  <= 32'd0;
            y_hi_reg  <= 32'd65536;
            mode_reg  <= 1'b0;
            inv_reg   <= 32'hFFFF_FFFF;
            shift_reg <= 6'd19;
        end
        else
        begin
            state_reg <= state_next;
            inv_reg   <= inv_next;
            shift_reg <= shift_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    msa_pkg::CFG_X_LO: x_lo_reg <= cfg_wdata;
                    msa_pkg::CFG_X_HI: x_hi_reg <= cfg_wdata;
                    msa_pkg::CFG_Y_LO: y_lo_reg <= cfg_wdata;
                    msa_pkg::CFG_Y_HI: y_hi_reg <= cfg_wdata;
                    msa_pkg::CFG_MODE: mode_reg <= cfg_wdata[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hn_reg  <= hn_next;
        z_reg   <= z_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign cfg.x_lo      = x_lo_reg;
    assign cfg.x_hi      = x_hi_reg;
    assign cfg.y_lo      = y_lo_reg;
    assign cfg.y_hi      = y_hi_reg;
    assign cfg.terrain   = mode_reg;
    assign cfg.inv       = inv_reg;
    assign cfg.inv_shift = shift_reg;
    assign cfg.busy      = (state_reg != RS_IDLE);

endmodule

>>> hdl/msa_dpath.sv
// Shared magnitude multiplier, product register, scale/saturate writeback,
// moment accumulators, count, min/max and the output register.
module msa_dpath #(
    parameter int ACC_WIDTH = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  msa_pkg::cmd_t cmd,
    input  msa_pkg::cfg_t cfg,
    input  logic [31:0]   in_x,
    input  logic [31:0]   in_y,
    input  logic [31:0]   in_h,
    output logic [4:0]    out_index,
    output logic [63:0]   out_value,
    output logic          out_last,
    output logic          out_sat
);

    localparam logic signed [65:0] ACC_MAX = (66'sd1 <<< (ACC_WIDTH - 1)) - 66'sd1;
    localparam logic signed [65:0] ACC_MIN = -ACC_MAX - 66'sd1;

    logic signed [ACC_WIDTH-1:0] acc_reg [msa_pkg::NUM_MOMENTS];

    logic signed [31:0] zh_reg;
    logic signed [34:0] d0_reg, d1_reg;
    logic signed [31:0] p0_reg, p1_reg;
    logic signed [32:0] xx_reg, xy_reg, yy_reg;
    logic signed [33:0] xxx_reg, xxy_reg, yyy_reg;

    logic [65:0] prod_reg;
    logic        wb_valid_reg;
    logic        wb_neg_reg;
    logic [1:0]  wb_shk_reg;
    logic [4:0]  wb_acc_reg;
    logic [3:0]  wb_tdst_reg;

    logic [31:0]        count_reg;
    logic signed [31:0] min_reg, max_reg;
    logic               flag_reg, flag_next;

    msa_pkg::step_t     info;
    logic signed [34:0] a_val, a_abs, twice_x, twice_y, sum_x, sum_y;
    logic signed [32:0] b_val, b_abs;
    logic [33:0]        a_mag;
    logic [31:0]        b_mag;

    logic [65:0]        r_sh;
    logic               p_sat;
    logic [63:0]        r_mag;
    logic signed [63:0] v;
    logic [4:0]         rd_addr;
    logic signed [ACC_WIDTH-1:0] acc_rd, acc_new;
    logic signed [65:0] acc_sum;
    logic               acc_hi, acc_lo;

    always_comb
    begin
        twice_x = $signed({{2{in_x[31]}}, in_x, 1'b0});
        twice_y = $signed({{2{in_y[31]}}, in_y, 1'b0});
        sum_x   = $signed({{3{cfg.x_lo[31]}}, cfg.x_lo}) + $signed({{3{cfg.x_hi[31]}}, cfg.x_hi});
        sum_y   = $signed({{3{cfg.y_lo[31]}}, cfg.y_lo}) + $signed({{3{cfg.y_hi[31]}}, cfg.y_hi});
    end

    // operand select and magnitude
    always_comb
    begin
        info = msa_pkg::step_info(cmd.step);
        case (info.opa)
            msa_pkg::A_ZH:  a_val = 35'(zh_reg);
            msa_pkg::A_D0:  a_val = d0_reg;
            msa_pkg::A_D1:  a_val = d1_reg;
            msa_pkg::A_P0:  a_val = 35'(p0_reg);
            msa_pkg::A_P1:  a_val = 35'(p1_reg);
            msa_pkg::A_XX:  a_val = 35'(xx_reg);
            msa_pkg::A_XY:  a_val = 35'(xy_reg);
            msa_pkg::A_YY:  a_val = 35'(yy_reg);
            msa_pkg::A_XXX: a_val = 35'(xxx_reg);
            msa_pkg::A_XXY: a_val = 35'(xxy_reg);
            msa_pkg::A_YYY: a_val = 35'(yyy_reg);
            default:        a_val = '0;
        endcase
        case (info.opb)
            msa_pkg::B_ONE: b_val = 33'sd1;
            msa_pkg::B_INV: b_val = $signed({1'b0, cfg.inv});
            msa_pkg::B_ZH:  b_val = 33'(zh_reg);
            msa_pkg::B_P0:  b_val = 33'(p0_reg);
            msa_pkg::B_P1:  b_val = 33'(p1_reg);
            default:        b_val = '0;
        endcase
        a_abs = a_val[34] ? (35'sd0 - a_val) : a_val;
        b_abs = b_val[32] ? (33'sd0 - b_val) : b_val;
        a_mag = a_abs[33:0];
        b_mag = b_abs[31:0];
    end

    // writeback: truncate toward zero, clamp offsets, saturating add
    always_comb
    begin
        case (wb_shk_reg)
            msa_pkg::SH_0:   r_sh = prod_reg;
            msa_pkg::SH_16:  r_sh = prod_reg >> 16;
            msa_pkg::SH_30:  r_sh = prod_reg >> 30;
            msa_pkg::SH_VAR: r_sh = prod_reg >> cfg.inv_shift;
            default:         r_sh = prod_reg;
        endcase
        p_sat = (wb_shk_reg == msa_pkg::SH_VAR) && (r_sh > msa_pkg::OFFS_LIM);
        r_mag = p_sat ? msa_pkg::OFFS_LIM[63:0] : r_sh[63:0];
        v     = wb_neg_reg ? (64'sd0 - $signed(r_mag)) : $signed(r_mag);

        rd_addr = cmd.rd_load ? cmd.rd_idx : wb_acc_reg;
        acc_rd  = (rd_addr < 5'(msa_pkg::NUM_MOMENTS)) ? acc_reg[rd_addr] : '0;
        acc_sum = 66'(acc_rd) + 66'(v);
        acc_hi  = acc_sum > ACC_MAX;
        acc_lo  = acc_sum < ACC_MIN;
        if (acc_hi)
        begin
            acc_new = ACC_MAX[ACC_WIDTH-1:0];
        end
        else if (acc_lo)
        begin
            acc_new = ACC_MIN[ACC_WIDTH-1:0];
        end
        else
        begin
            acc_new = acc_sum[ACC_WIDTH-1:0];
        end

        flag_next = flag_reg;
        if (wb_valid_reg && (p_sat || acc_hi || acc_lo))
        begin
            flag_next = 1'b1;
        end
        if (cmd.load && (count_reg == 32'hFFFF_FFFF))
        begin
            flag_next = 1'b1;
        end
        if (cmd.clear)
        begin
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < msa_pkg::NUM_MOMENTS; k++)
            begin
                acc_reg[k] <= '0;
            end
            wb_valid_reg <= 1'b0;
            count_reg    <= '0;
            min_reg      <= 32'sh7FFF_FFFF;
            max_reg      <= 32'sh8000_0000;
            flag_reg     <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= cmd.issue;
            flag_reg     <= flag_next;
            if (cmd.clear)
            begin
                for (int k = 0; k < msa_pkg::NUM_MOMENTS; k++)
                begin
                    acc_reg[k] <= '0;
                end
                count_reg <= '0;
                min_reg   <= 32'sh7FFF_FFFF;
                max_reg   <= 32'sh8000_0000;
            end
            else
            begin
                if (wb_valid_reg)
                begin
                    acc_reg[wb_acc_reg] <= acc_new;
                end
                if (cmd.load)
                begin
                    if (count_reg != 32'hFFFF_FFFF)
                    begin
                        count_reg <= count_reg + 32'd1;
                    end
                    if ($signed(in_h) < min_reg)
                    begin
                        min_reg <= $signed(in_h);
                    end
                    if ($signed(in_h) > max_reg)
                    begin
                        max_reg <= $signed(in_h);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            zh_reg <= $signed(in_h);
            d0_reg <= twice_x - sum_x;
            d1_reg <= twice_y - sum_y;
        end
        if (cmd.issue)
        begin
            prod_reg    <= {32'd0, a_mag} * {34'd0, b_mag};
            wb_neg_reg  <= a_val[34] ^ b_val[32];
            wb_shk_reg  <= info.shk;
            wb_acc_reg  <= info.acc;
            wb_tdst_reg <= info.tdst;
        end
        if (wb_valid_reg)
        begin
            case (wb_tdst_reg)
                msa_pkg::T_P0:  p0_reg  <= v[31:0];
                msa_pkg::T_P1:  p1_reg  <= v[31:0];
                msa_pkg::T_XX:  xx_reg  <= v[32:0];
                msa_pkg::T_XY:  xy_reg  <= v[32:0];
                msa_pkg::T_YY:  yy_reg  <= v[32:0];
                msa_pkg::T_XXX: xxx_reg <= v[33:0];
                msa_pkg::T_XXY: xxy_reg <= v[33:0];
                msa_pkg::T_YYY: yyy_reg <= v[33:0];
                default:
                begin
                end
            endcase
        end
        if (cmd.rd_load)
        begin
            out_index <= cmd.rd_idx;
            out_last  <= (cmd.rd_idx == msa_pkg::IDX_MAX);
            out_sat   <= flag_reg;
            case (cmd.rd_idx)
                msa_pkg::IDX_COUNT: out_value <= {32'd0, count_reg};
                msa_pkg::IDX_MIN:   out_value <= 64'(min_reg);
                msa_pkg::IDX_MAX:   out_value <= 64'(max_reg);
                default:            out_value <= 64'(acc_rd);
            endcase
        end
    end

endmodule

>>> hdl/msa_ctrl.sv
// Command sequencer: takes an item, steps the multiply schedule, paces readout.
module msa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    in_cmd,
    output logic          in_ready,
    input  logic          busy,
    input  logic          terrain,
    output logic          out_valid,
    input  logic          out_ready,
    output msa_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [4:0] idx_reg, idx_next;
    logic       terr_reg, terr_next;
    logic       ov_reg, ov_next;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE) && !busy;
    assign accept    = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        terr_next  = terr_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        cmd.rd_idx = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_cmd)
                        msa_pkg::CMD_ADD:
                        begin
                            cmd.load   = 1'b1;
                            terr_next  = terrain;
                            step_next  = msa_pkg::STEP_H0;
                            state_next = ST_CALC;
                        end
                        msa_pkg::CMD_READ:
                        begin
                            idx_next   = '0;
                            state_next = ST_READ;
                        end
                        msa_pkg::CMD_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CALC:
            begin
                cmd.issue = 1'b1;
                if (terr_reg || (step_reg == msa_pkg::STEP_LAST))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_READ:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.rd_load = 1'b1;
                    if (idx_reg == msa_pkg::IDX_MAX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.rd_load)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            idx_reg   <= '0;
            terr_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            terr_reg  <= terr_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

>>> hdl/moment_sum_accumulator.sv
// Channel   Group                     Fields (low bit up)
// -------   -----------------------   ----------------------------------------
// config    cfg_we/cfg_index/wdata    index 0..3 rectangle bounds, 4 terrain mode
// in        s_axis_*                  tuser: cmd; tdata: point_x, point_y, height
// out       m_axis_*                  tuser: sum_index, saturated; tdata: sum_value
//
// An add transfer is accepted, then runs the 21 steps of one shared 34x32
// magnitude multiplier (just the first step in terrain mode); clear acts on accept.
// A readout emits 24 transfers, one per cycle when m_axis_tready stays high.
// A write to a bound register starts the reciprocal unit (load, normalize,
// then divide), during which s_axis_tready is low.
// Reset (rst_n low, asynchronous) restores registers, sums and reciprocal.
// A stalled output holds its transfer; the next input may still be taken.
module moment_sum_accumulator #(
    parameter int ACC_WIDTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // point_x, point_y, point_height
    input  logic [1:0]  s_axis_tuser,   // cmd

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // sum_value
    output logic [5:0]  m_axis_tuser,   // sum_index, saturated
    output logic        m_axis_tlast    // last_of_run
);

    msa_pkg::cfg_t cfg;
    msa_pkg::cmd_t cmd;
    logic [4:0]    sum_index;
    logic          saturated;

    // config registers and extent reciprocal
    msa_recip u_recip
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // sequencer
    msa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_cmd    (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .busy      (cfg.busy),
        .terrain   (cfg.terrain),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    // arithmetic, sums and output register
    msa_dpath #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg),
        .in_x      (s_axis_tdata[31:0]),
        .in_y      (s_axis_tdata[63:32]),
        .in_h      (s_axis_tdata[95:64]),
        .out_index (sum_index),
        .out_value (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_sat   (saturated)
    );

    assign m_axis_tuser = {saturated, sum_index};

`ifndef SYNTHESIS
    // tlast marks exactly the final value of a run
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[4:0] == msa_pkg::IDX_MAX)))
        else $error("tlast does not match the last index");

    // a bound write holds off input while the reciprocal is rebuilt
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index <= msa_pkg::CFG_Y_HI)) |=> !s_axis_tready)
        else $error("input taken during reciprocal update");

    // a readout owns the block until its run is issued
    a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == msa_pkg::CMD_READ))
        |=> !s_axis_tready)
        else $error("input taken at readout start");
`endif

endmodule
